/* rtl/half_md4_name_hash_core_assert.svh */
// Assertion macros shared by the name hash RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef HALF_MD4_NAME_HASH_CORE_ASSERT_SVH
`define HALF_MD4_NAME_HASH_CORE_ASSERT_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define HMD4_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while the active-low reset is asserted.
`define HMD4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hmd4_pkg.sv */
// Types, constants and step tables for the Half-MD4 name hash.
// No dependencies; used by hmd4_step and half_md4_name_hash_core.
package hmd4_pkg;

    typedef logic [31:0]          word_t;
    typedef logic [3:0][31:0]     chain_t;
    typedef logic [7:0][3:0][7:0] block_t;
    typedef logic [4:0]           step_t;
    typedef logic [4:0]           pos_t;

    localparam step_t LAST_STEP = 5'd23;

    localparam word_t ROUND2_ADD = 32'h5A827999;
    localparam word_t ROUND3_ADD = 32'h6ED9EBA1;

    localparam chain_t CHAIN_INIT = {32'h10325476, 32'h98BADCFE,
                                     32'hEFCDAB89, 32'h67452301};

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_FOLD  = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    // Message word taken by each of the 24 steps.
    function automatic logic [2:0] word_sel(input step_t step);
        logic [2:0] sel;
        case (step)
            5'd0:    sel = 3'd0;
            5'd1:    sel = 3'd1;
            5'd2:    sel = 3'd2;
            5'd3:    sel = 3'd3;
            5'd4:    sel = 3'd4;
            5'd5:    sel = 3'd5;
            5'd6:    sel = 3'd6;
            5'd7:    sel = 3'd7;
            5'd8:    sel = 3'd1;
            5'd9:    sel = 3'd3;
            5'd10:   sel = 3'd5;
            5'd11:   sel = 3'd7;
            5'd12:   sel = 3'd0;
            5'd13:   sel = 3'd2;
            5'd14:   sel = 3'd4;
            5'd15:   sel = 3'd6;
            5'd16:   sel = 3'd3;
            5'd17:   sel = 3'd7;
            5'd18:   sel = 3'd2;
            5'd19:   sel = 3'd6;
            5'd20:   sel = 3'd1;
            5'd21:   sel = 3'd5;
            5'd22:   sel = 3'd0;
            5'd23:   sel = 3'd4;
            default: sel = 3'd0;
        endcase
        return sel;
    endfunction

    // Left-rotate amount of each step.
    function automatic logic [4:0] rot_amt(input step_t step);
        logic [4:0] amt;
        case (step[4:3])
            2'd0: begin
                case (step[1:0])
                    2'd0:    amt = 5'd3;
                    2'd1:    amt = 5'd7;
                    2'd2:    amt = 5'd11;
                    default: amt = 5'd19;
                endcase
            end
            2'd1: begin
                case (step[1:0])
                    2'd0:    amt = 5'd3;
                    2'd1:    amt = 5'd5;
                    2'd2:    amt = 5'd9;
                    default: amt = 5'd13;
                endcase
            end
            default: begin
                case (step[1:0])
                    2'd0:    amt = 5'd3;
                    2'd1:    amt = 5'd9;
                    2'd2:    amt = 5'd11;
                    default: amt = 5'd15;
                endcase
            end
        endcase
        return amt;
    endfunction

    // Working word updated by a step: a, d, c, b in turn.
    function automatic logic [1:0] target_sel(input step_t step);
        return 2'(2'd0 - step[1:0]);
    endfunction

endpackage

/* rtl/hmd4_step.sv */
// One Half-MD4 step: round function, add of message word, rotate.
// Depends on hmd4_pkg; reused for all 24 steps by the core's sequencer.
module hmd4_step (
    input  hmd4_pkg::step_t  step,
    input  hmd4_pkg::chain_t work_words,
    input  hmd4_pkg::block_t block_words,
    output logic [1:0]       target,
    output hmd4_pkg::word_t  new_word
);

    logic [1:0]      t;
    hmd4_pkg::word_t x, y, z, f, sum;
    logic [4:0]      amt;

    always_comb begin
        t   = hmd4_pkg::target_sel(step);
        x   = work_words[2'(t + 2'd1)];
        y   = work_words[2'(t + 2'd2)];
        z   = work_words[2'(t + 2'd3)];
        amt = hmd4_pkg::rot_amt(step);
        case (step[4:3])
            2'd0:    f = (x & y) | (~x & z);
            2'd1:    f = ((x & y) | (x & z) | (y & z)) + hmd4_pkg::ROUND2_ADD;
            default: f = (x ^ y ^ z) + hmd4_pkg::ROUND3_ADD;
        endcase
        sum      = work_words[t] + f + block_words[hmd4_pkg::word_sel(step)];
        new_word = (sum << amt) | (sum >> (6'd32 - {1'b0, amt}));
        target   = t;
    end

endmodule

/* rtl/half_md4_name_hash_core.sv */
// Half-MD4 name hash core; uses hmd4_pkg, hmd4_step and the assertion macro header.
// A byte request that leaves the 32-byte block unfilled leaves the core idle. One that fills
// the block, or ends a name with bytes pending, holds ready low through 24 steps on the
// shared hmd4_step unit and a fold. A name end then passes a finish state, which shows its
// hash once any older hash has been taken; an end on an empty block goes straight there.
// aresetn is synchronous, active low: MD4 chaining values, empty block, no result pending.
`include "half_md4_name_hash_core_assert.svh"

module half_md4_name_hash_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value
);

    // Sequencer state and counters.
    hmd4_pkg::state_t state_reg, state_next;
    hmd4_pkg::step_t  step_reg, step_next;
    hmd4_pkg::pos_t   pos_reg, pos_next;
    logic             end_pending_reg, end_pending_next;

    // Hash state: chaining words, message block and the working words of
    // the transform in progress.
    hmd4_pkg::chain_t chain_reg, chain_next;
    hmd4_pkg::block_t block_reg, block_next;
    hmd4_pkg::chain_t work_reg, work_next;

    // Output register; it holds a finished hash while new bytes come in.
    logic             m_valid_reg, m_valid_next;
    hmd4_pkg::word_t  hash_reg, hash_next;

    logic [1:0]       step_target;
    hmd4_pkg::word_t  step_word;
    logic             accept;
    logic             out_free;

    hmd4_step u_step (
        .step        (step_reg),
        .work_words  (work_reg),
        .block_words (block_reg),
        .target      (step_target),
        .new_word    (step_word)
    );

    assign s_ready      = (state_reg == hmd4_pkg::ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_hash_value = hash_reg;

    always_comb begin
        state_next       = state_reg;
        step_next        = step_reg;
        pos_next         = pos_reg;
        end_pending_next = end_pending_reg;
        chain_next       = chain_reg;
        block_next       = block_reg;
        work_next        = work_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        hash_next        = hash_reg;

        case (state_reg)
            hmd4_pkg::ST_IDLE: begin
                if (accept) begin
                    end_pending_next = s_last_byte;
                    step_next        = '0;
                    work_next        = chain_reg;
                    if (s_has_byte) begin
                        // The block is cleared after every transform, so a
                        // plain write of the byte lane is the same as an OR.
                        block_next[pos_reg[4:2]][pos_reg[1:0]] = s_data_byte;
                        pos_next = 5'(pos_reg + 5'd1);
                        // A full block or a name end starts the transform.
                        if (pos_reg == 5'd31 || s_last_byte) begin
                            state_next = hmd4_pkg::ST_ROUND;
                        end
                    end else if (s_last_byte) begin
                        // A name end without a byte only transforms a
                        // partly filled block.
                        if (pos_reg != 5'd0) begin
                            state_next = hmd4_pkg::ST_ROUND;
                        end else begin
                            state_next = hmd4_pkg::ST_FIN;
                        end
                    end
                end
            end
            hmd4_pkg::ST_ROUND: begin
                work_next[step_target] = step_word;
                step_next              = 5'(step_reg + 5'd1);
                if (step_reg == hmd4_pkg::LAST_STEP) begin
                    state_next = hmd4_pkg::ST_FOLD;
                end
            end
            hmd4_pkg::ST_FOLD: begin
                for (int i = 0; i < 4; i++) begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                block_next = '0;
                state_next = end_pending_reg ? hmd4_pkg::ST_FIN : hmd4_pkg::ST_IDLE;
            end
            hmd4_pkg::ST_FIN: begin
                // Wait for the output register, then publish and restart.
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    hash_next        = (chain_reg[1] == 32'd0) ? 32'd1 : chain_reg[1];
                    chain_next       = hmd4_pkg::CHAIN_INIT;
                    block_next       = '0;
                    pos_next         = '0;
                    end_pending_next = 1'b0;
                    state_next       = hmd4_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hmd4_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= hmd4_pkg::ST_IDLE;
            step_reg        <= '0;
            pos_reg         <= '0;
            end_pending_reg <= 1'b0;
            chain_reg       <= hmd4_pkg::CHAIN_INIT;
            block_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            pos_reg         <= pos_next;
            end_pending_reg <= end_pending_next;
            chain_reg       <= chain_next;
            block_reg       <= block_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        hash_reg <= hash_next;
    end

    // The step counter never runs past the last step of the transform.
    `HMD4_ASSERT_NOW(a_step_range, aclk, aresetn, state_reg == hmd4_pkg::ST_ROUND, step_reg <= hmd4_pkg::LAST_STEP, "step counter out of range")
    // After a fold the message block is empty for the next bytes.
    `HMD4_ASSERT_NEXT(a_block_cleared, aclk, aresetn, state_reg == hmd4_pkg::ST_FOLD, block_reg == '0, "block not cleared after fold")
    // A finish with a free output register always presents a result.
    `HMD4_ASSERT_NEXT(a_fin_publishes, aclk, aresetn, (state_reg == hmd4_pkg::ST_FIN) && out_free, m_valid && (state_reg == hmd4_pkg::ST_IDLE), "finish did not publish")
    // The reported hash is never zero.
    `HMD4_ASSERT_NOW(a_hash_nonzero, aclk, aresetn, m_valid, m_hash_value != 32'd0, "zero hash reported")

endmodule

/* tb/name_hash_checker.sv */
// Scoreboard for the Half-MD4 name hash core: watches both channels, predicts each hash.
// Depends on hmd4_pkg for the word type, the MD4 chaining start values and round constants.
module name_hash_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_last_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_hash_value,
    output int          mismatch_count,
    output int          hashes_pending,
    output int          hashes_checked
);

    localparam int unsigned MSG_INDEX[24] = '{
        0, 1, 2, 3, 4, 5, 6, 7,
        1, 3, 5, 7, 0, 2, 4, 6,
        3, 7, 2, 6, 1, 5, 0, 4
    };
    localparam int unsigned ROT_LEFT[24] = '{
        3, 7, 11, 19, 3, 7, 11, 19,
        3, 5, 9, 13, 3, 5, 9, 13,
        3, 9, 11, 15, 3, 9, 11, 15
    };
    localparam int unsigned DEST_REG[4] = '{0, 3, 2, 1};

    hmd4_pkg::word_t hash_state[4];
    hmd4_pkg::word_t msg_buf[8];
    hmd4_pkg::pos_t  fill_count;
    hmd4_pkg::word_t expected_hashes[$];

    function automatic hmd4_pkg::word_t rotl(input hmd4_pkg::word_t w, input int unsigned s);
        return (w << s) | (w >> (32 - s));
    endfunction

    function automatic void clear_msg();
        for (int k = 0; k < 8; k++) msg_buf[k] = '0;
    endfunction

    function automatic void start_name();
        for (int k = 0; k < 4; k++) hash_state[k] = hmd4_pkg::CHAIN_INIT[k];
        clear_msg();
        fill_count = '0;
    endfunction

    // 24 steps over the buffered block, then add into the chaining words.
    function automatic void mix_block();
        hmd4_pkg::word_t v[4];
        hmd4_pkg::word_t x, y, z, f;
        int unsigned     t;
        for (int k = 0; k < 4; k++) v[k] = hash_state[k];
        for (int i = 0; i < 24; i++) begin
            t = DEST_REG[i % 4];
            x = v[(t + 1) % 4];
            y = v[(t + 2) % 4];
            z = v[(t + 3) % 4];
            if (i < 8)
                f = (x & y) | (~x & z);
            else if (i < 16)
                f = ((x & y) | (x & z) | (y & z)) + hmd4_pkg::ROUND2_ADD;
            else
                f = (x ^ y ^ z) + hmd4_pkg::ROUND3_ADD;
            v[t] = rotl(v[t] + f + msg_buf[MSG_INDEX[i]], ROT_LEFT[i]);
        end
        for (int k = 0; k < 4; k++) hash_state[k] += v[k];
    endfunction

    function automatic void take_request(input logic [7:0] data, input logic has_b,
                                         input logic end_b);
        hmd4_pkg::word_t h;
        if (has_b) begin
            msg_buf[fill_count[4:2]][8 * fill_count[1:0] +: 8] = data;
            fill_count = fill_count + 1'b1;
            if (fill_count == '0) begin
                mix_block();
                clear_msg();
            end
        end
        if (end_b) begin
            // A name that ended exactly on a block boundary gets no extra block.
            if (fill_count != '0) mix_block();
            h = hash_state[1];
            if (h == '0) h = 32'd1;
            expected_hashes.push_back(h);
            start_name();
        end
    endfunction

    initial start_name();

    always @(posedge aclk) begin
        if (!aresetn) begin
            start_name();
            expected_hashes.delete();
        end else begin
            // Results are matched first, so a result can never be paired with a
            // prediction made by a request taken at the same edge.
            if (m_valid && m_ready) begin
                if (expected_hashes.size() == 0) begin
                    $error("hash_value: expected none, got %h", m_hash_value);
                    mismatch_count++;
                end else begin
                    if (m_hash_value !== expected_hashes[0]) begin
                        $error("hash_value: expected %h, got %h",
                               expected_hashes[0], m_hash_value);
                        mismatch_count++;
                    end
                    void'(expected_hashes.pop_front());
                    hashes_checked++;
                end
            end
            if (s_valid && s_ready)
                take_request(s_data_byte, s_has_byte, s_last_byte);
        end
        hashes_pending = expected_hashes.size();
    end

endmodule

/* tb/testbench.sv */
// Top of the Half-MD4 name hash testbench: clock, reset, request and result traffic.
// Depends on half_md4_name_hash_core (with hmd4_pkg) and name_hash_checker.
module testbench;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_has_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_hash_value;

    int mismatch_count;
    int hashes_pending;
    int hashes_checked;

    // Sender bookkeeping. Every request taken counts toward the budget,
    // the empty items that the core simply drops included.
    int requests_sent;
    int names_sent;
    int burst_left;

    // Set by the stimulus to ask the receiver for one long stall; the
    // receiver clears it once it has started holding off.
    bit hold_off_req;

    half_md4_name_hash_core u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_has_byte   (s_has_byte),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    name_hash_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_has_byte     (s_has_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash_value   (m_hash_value),
        .mismatch_count (mismatch_count),
        .hashes_pending (hashes_pending),
        .hashes_checked (hashes_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // The worst correct run is far below this: each request costs at most
    // one transform and finish in the core, a sender gap and a short receiver stall.
    initial begin
        #4800000;
        $display("FAIL");
        $finish;
    end

    // Receiver: alternates between spans of always ready, coin-flip ready
    // and mostly stalled, so that stalls land on every phase of the core.
    // A long hold-off is counted here in cycles when the stimulus asks.
    initial begin : receiver
        int mode;
        int span;
        m_ready = 1'b0;
        mode    = 0;
        span    = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready      <= 1'b0;
                hold_off_req = 1'b0;
                repeat (400) @(negedge aclk);
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 2);
                    span = $urandom_range(5, 60);
                end
                span--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offers one request and returns at the rising edge where it is taken.
    // The sender works in bursts; between bursts valid usually drops,
    // and now and then a burst follows with no gap at all.
    task automatic offer(input logic [7:0] data, input bit has_b, input bit end_b);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_data_byte <= data;
        s_has_byte  <= has_b;
        s_last_byte <= end_b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
    endtask

    // Stops offering and waits until every predicted hash has come out.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (hashes_pending != 0) @(negedge aclk);
        burst_left = 0;
    endtask

    // Sends one name of len bytes with random content and a sprinkling of
    // empty items. The name ends either on its last byte or with a
    // separate end request that carries no byte.
    task automatic send_name(input int len, input bit end_on_byte);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) offer(8'($urandom), 1'b0, 1'b0);
            offer(8'($urandom), 1'b1, end_on_byte && (k == len - 1));
        end
        if (!end_on_byte || len == 0) offer(8'($urandom), 1'b0, 1'b1);
        names_sent++;
    endtask

    // Most names are short; a good share sit on or next to a block
    // boundary, and some are empty.
    function automatic int pick_name_length();
        int boundary_len[6] = '{31, 32, 33, 63, 64, 65};
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 8)
            return $urandom_range(1, 8);
        else if (pick < 12)
            return $urandom_range(9, 31);
        else if (pick < 17)
            return boundary_len[$urandom_range(0, 5)];
        else
            return 0;
    endfunction

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data_byte   = 8'h00;
        s_has_byte    = 1'b0;
        s_last_byte   = 1'b0;
        requests_sent = 0;
        names_sent    = 0;
        burst_left    = 0;
        hold_off_req  = 1'b0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. An empty item must change nothing, and an end
        // request with no bytes taken gives the untouched chaining word 1.
        offer(8'h00, 1'b0, 1'b0);
        offer(8'hFF, 1'b0, 1'b1);
        // Single-byte names ending on the byte itself, at both data extremes.
        offer(8'h00, 1'b1, 1'b1);
        offer(8'hFF, 1'b1, 1'b1);
        // Two bytes with an empty item between them, ended without a byte.
        offer(8'hA5, 1'b1, 1'b0);
        offer(8'h5A, 1'b0, 1'b0);
        offer(8'h3C, 1'b1, 1'b0);
        offer(8'hC3, 1'b0, 1'b1);
        offer(8'h80, 1'b1, 1'b0);
        offer(8'h01, 1'b1, 1'b1);
        names_sent = 5;
        wait_drained();

        // Exact block multiples both ways: the 32nd byte carries the end,
        // or a separate end request follows a full block.
        send_name(32, 1'b1);
        send_name(32, 1'b0);
        send_name(64, 1'b1);

        // Random names until the request budget is used up. Early on the
        // receiver is asked for one long stall while the sender keeps
        // offering, so the core backs up and holds off its input; later
        // the sender pauses once until every hash is back.
        while (requests_sent < 950) begin
            if (names_sent == 12) hold_off_req = 1'b1;
            if (names_sent == 30) wait_drained();
            send_name(pick_name_length(), 1'($urandom_range(0, 1)));
        end

        wait_drained();
        repeat (40) @(posedge aclk);

        $display("Hashed %0d names from %0d requests; %0d hashes compared, %0d mismatches.",
                 names_sent, requests_sent, hashes_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
